// ===== hw/rtl/tpp_pkg.sv =====
package tpp_pkg;

	localparam int POS_W       = 32;
	localparam int IN_W        = 96;
	localparam int SQRT_STAGES = 32;
	localparam int DIV_QBITS   = 50;
	localparam int DIV_NBITS   = 82;
	localparam int DIV_DBITS   = 64;

	localparam logic [POS_W-1:0] CFG_RESET = 32'h0001_0000;

	typedef enum logic [0:0] {
		REG_MAX_VELOCITY = 1'b0,
		REG_ACCELERATION = 1'b1
	} cfg_reg_t;

	// profile segment a sample falls in
	typedef enum logic [1:0] {
		BR_ACCEL  = 2'd0,
		BR_CRUISE = 2'd1,
		BR_DECEL  = 2'd2
	} br_t;

	typedef struct packed {
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] target;
		logic [POS_W-1:0] elapsed;
		logic [POS_W-1:0] distance;
		logic             neg;
		logic             zero;
	} move_t;

	typedef struct packed {
		logic  avail;
		move_t mv;
	} qhead_t;

endpackage

// ===== hw/rtl/tpp_front.sv =====
module tpp_front (
	input  logic                     in_valid,
	input  logic [tpp_pkg::IN_W-1:0] in_data,
	output logic                     in_ready,
	input  logic                     full,
	output logic                     wr,
	output tpp_pkg::move_t           mv
);

	logic [32:0] diff;
	logic [32:0] mag;

	always_comb begin
		diff = {in_data[63], in_data[63:32]} - {in_data[31], in_data[31:0]};
		mag  = diff[32] ? (33'd0 - diff) : diff;
		mv.start    = in_data[31:0];
		mv.target   = in_data[63:32];
		mv.elapsed  = in_data[95:64];
		mv.distance = mag[31:0];
		mv.neg      = diff[32];
		mv.zero     = (diff == 33'd0);
	end

	assign in_ready = !full;
	assign wr       = in_valid && !full;

endmodule

// ===== hw/rtl/tpp_queue.sv =====
module tpp_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  tpp_pkg::move_t  wdata,
	output logic            full,
	input  logic            pop,
	output tpp_pkg::qhead_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tpp_pkg::move_t mem_q [DEPTH];
	logic [AW-1:0]  wp_q;
	logic [AW-1:0]  rp_q;
	logic [CW-1:0]  cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head.avail = (cnt_q != '0);
	assign head.mv    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			priority if (wr && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				cnt_q <= cnt_q;
			end
		end
	end

endmodule

// ===== hw/rtl/tpp_isqrt.sv =====
module tpp_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] radicand,
	output logic [31:0] root
);

	localparam int N = tpp_pkg::SQRT_STAGES;

	logic [63:0] x_q  [N];
	logic [63:0] r_q  [N];
	logic [63:0] x_nx [N];
	logic [63:0] r_nx [N];

	// one result bit per stage, trial bit walks down two places a stage
	always_comb begin
		logic [63:0] xin;
		logic [63:0] rin;
		logic [63:0] bitv;
		logic [63:0] trial;
		for (int i = 0; i < N; i++) begin
			xin   = (i == 0) ? radicand : x_q[(i == 0) ? 0 : i - 1];
			rin   = (i == 0) ? 64'd0 : r_q[(i == 0) ? 0 : i - 1];
			bitv  = 64'd1 << (62 - 2 * i);
			trial = rin + bitv;
			if (xin >= trial) begin
				x_nx[i] = xin - trial;
				r_nx[i] = (rin >> 1) + bitv;
			end else begin
				x_nx[i] = xin;
				r_nx[i] = rin >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				x_q[i] <= x_nx[i];
				r_q[i] <= r_nx[i];
			end
		end
	end

	assign root = r_q[N-1][31:0];

endmodule

// ===== hw/rtl/tpp_div.sv =====
module tpp_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [tpp_pkg::DIV_NBITS-1:0] dividend,
	input  logic [tpp_pkg::DIV_DBITS-1:0] divisor,
	output logic [tpp_pkg::DIV_QBITS-1:0] quotient
);

	localparam int QB = tpp_pkg::DIV_QBITS;
	localparam int DW = tpp_pkg::DIV_DBITS;
	localparam int NW = tpp_pkg::DIV_NBITS;

	logic [DW-1:0] rem_q  [QB];
	logic [QB-1:0] lo_q   [QB];
	logic [DW-1:0] den_q  [QB];
	logic [DW-1:0] rem_nx [QB];
	logic [QB-1:0] lo_nx  [QB];

	// restoring division, one quotient bit per stage; lo holds the dividend
	// bits still to come on top and the quotient bits found so far below
	always_comb begin
		logic [DW-1:0] rin;
		logic [QB-1:0] lin;
		logic [DW-1:0] din;
		logic [DW:0]   trial;
		logic          ge;
		for (int i = 0; i < QB; i++) begin
			rin   = (i == 0) ? DW'(dividend[NW-1:QB]) : rem_q[(i == 0) ? 0 : i - 1];
			lin   = (i == 0) ? dividend[QB-1:0] : lo_q[(i == 0) ? 0 : i - 1];
			din   = (i == 0) ? divisor : den_q[(i == 0) ? 0 : i - 1];
			trial = {rin, lin[QB-1]};
			ge    = (trial >= {1'b0, din});
			rem_nx[i] = ge ? DW'(trial - {1'b0, din}) : trial[DW-1:0];
			lo_nx[i]  = {lin[QB-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_q[0] <= divisor;
			for (int i = 0; i < QB; i++) begin
				rem_q[i] <= rem_nx[i];
				lo_q[i]  <= lo_nx[i];
			end
			for (int i = 1; i < QB; i++) begin
				den_q[i] <= den_q[i-1];
			end
		end
	end

	assign quotient = lo_q[QB-1];

endmodule

// ===== hw/rtl/tpp_back.sv =====
module tpp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  tpp_pkg::qhead_t head,
	output logic            pop,
	input  logic [31:0]     vel,
	input  logic [31:0]     acc,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [31:0]     out_pos
);

	localparam int SQN = tpp_pkg::SQRT_STAGES;
	localparam int DVN = tpp_pkg::DIV_QBITS;

	typedef struct packed {
		tpp_pkg::move_t mv;
		logic           capped;
	} sq_side_t;

	typedef struct packed {
		tpp_pkg::move_t mv;
		tpp_pkg::br_t   br;
		logic           done;
		logic [62:0]    sacc;
	} dv_side_t;

	logic adv;

	// s1: distance times acceleration, velocity squared
	logic           v_s1;
	tpp_pkg::move_t mv_s1;
	logic [63:0]    da_s1, vv_s1;

	// square root alignment line
	logic [SQN-1:0] sqv_q;
	sq_side_t       sq_q [SQN];
	logic [31:0]    root;

	// s2: peak velocity and time products
	logic           v_s2;
	tpp_pkg::move_t mv_s2;
	logic [31:0]    vu_s2;
	logic [63:0]    ta_s2, tvu_s2;

	// s3: segment and partial products
	logic           v_s3;
	tpp_pkg::move_t mv_s3;
	tpp_pkg::br_t   br_s3;
	logic [63:0]    ptvl_s3, ptvh_s3, ptal_s3, ptah_s3, vv_s3, va_s3, da_s3;

	// s4: wide products
	logic           v_s4;
	tpp_pkg::move_t mv_s4;
	tpp_pkg::br_t   br_s4;
	logic [95:0]    p1_s4, p2_s4;
	logic [63:0]    vv_s4, va_s4, da_s4;

	// s5: numerators
	logic           v_s5;
	tpp_pkg::move_t mv_s5;
	tpp_pkg::br_t   br_s5;
	logic [62:0]    sacc_s5;
	logic [96:0]    num_s5;
	logic [81:0]    xm_s5;
	logic           done_s5;
	logic [63:0]    va_s5;

	// s6: divider operands
	logic           v_s6;
	tpp_pkg::move_t mv_s6;
	tpp_pkg::br_t   br_s6;
	logic [62:0]    sacc_s6;
	logic           done_s6;
	logic [81:0]    nd_s6;
	logic [63:0]    den_s6;

	// divider alignment line
	logic [DVN-1:0] dvv_q;
	dv_side_t       dv_q [DVN];
	logic [DVN-1:0] quot;

	// s7..s13: remaining time squared, segment select, output
	logic        v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;
	dv_side_t    sd_s7, sd_s8, sd_s9, sd_s10, sd_s11, sd_s12;
	tpp_pkg::move_t mv_s13;
	logic [DVN-1:0] q_s7, q_s8, q_s9, q_s10, q_s11;
	logic [63:0] aql_s7;
	logic [49:0] aqh_s7;
	logic [63:0] m_s8;
	logic [63:0] pll_s9, phl_s9;
	logic [49:0] plh_s9, phh_s9;
	logic [113:0] prod_s10;
	logic [63:0] d_s11;
	logic [31:0] s_s12;
	logic [31:0] pos_s13;

	// combinational
	logic [31:0]  vu_c;
	tpp_pkg::br_t br_c;
	logic [64:0]  xs_c;
	logic [96:0]  xw_c, p1w_c, sacc_c;
	logic [97:0]  cr_c;
	logic [114:0] y_c;
	logic [63:0]  d_c, dist64_c, sx_c;

	assign adv = !v_s13 || out_ready;
	assign pop = adv && head.avail;

	always_comb begin
		vu_c = sq_q[SQN-1].capped ? vel : root;

		priority if (ta_s2 <= {16'd0, vu_s2, 16'd0}) begin
			br_c = tpp_pkg::BR_ACCEL;
		end else if (tvu_s2 <= {16'd0, mv_s2.distance, 16'd0}) begin
			br_c = tpp_pkg::BR_CRUISE;
		end else begin
			br_c = tpp_pkg::BR_DECEL;
		end

		xs_c   = {1'b0, da_s4} + {1'b0, vv_s4};
		xw_c   = {16'd0, xs_c, 16'd0};
		p1w_c  = {1'b0, p1_s4};
		sacc_c = {1'b0, p2_s4} + {64'd0, 33'h1_0000_0000};

		cr_c = {1'b0, num_s5} + {50'd0, acc, 16'd0};

		y_c = {1'b0, prod_s10} + {82'd0, 33'h1_0000_0000};
		d_c = (|y_c[114:97]) ? {64{1'b1}} : y_c[96:33];

		dist64_c = {32'd0, sd_s11.mv.distance};
		unique case (sd_s11.br)
			tpp_pkg::BR_ACCEL:  sx_c = {1'b0, sd_s11.sacc};
			tpp_pkg::BR_CRUISE: sx_c = 64'(q_s11);
			tpp_pkg::BR_DECEL: begin
				if (sd_s11.done) begin
					sx_c = dist64_c;
				end else begin
					sx_c = (d_s11 >= dist64_c) ? 64'd0 : dist64_c - d_s11;
				end
			end
			default: sx_c = 64'd0;
		endcase
	end

	tpp_isqrt u_isqrt (
		.clk      (clk),
		.en       (adv),
		.radicand (da_s1),
		.root     (root)
	);

	tpp_div u_div (
		.clk      (clk),
		.en       (adv),
		.dividend (nd_s6),
		.divisor  (den_s6),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			sqv_q <= '0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			dvv_q <= '0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (adv) begin
			v_s1  <= head.avail;
			sqv_q <= {sqv_q[SQN-2:0], v_s1};
			v_s2  <= sqv_q[SQN-1];
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			dvv_q <= {dvv_q[DVN-2:0], v_s6};
			v_s7  <= dvv_q[DVN-1];
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mv_s1 <= head.mv;
			da_s1 <= 64'(head.mv.distance) * 64'(acc);
			vv_s1 <= 64'(vel) * 64'(vel);

			sq_q[0] <= '{mv: mv_s1, capped: (da_s1 > vv_s1)};
			for (int i = 1; i < SQN; i++) begin
				sq_q[i] <= sq_q[i-1];
			end

			mv_s2  <= sq_q[SQN-1].mv;
			vu_s2  <= vu_c;
			ta_s2  <= 64'(sq_q[SQN-1].mv.elapsed) * 64'(acc);
			tvu_s2 <= 64'(sq_q[SQN-1].mv.elapsed) * 64'(vu_c);

			mv_s3   <= mv_s2;
			br_s3   <= br_c;
			ptvl_s3 <= 64'(tvu_s2[31:0]) * 64'(acc);
			ptvh_s3 <= 64'(tvu_s2[63:32]) * 64'(acc);
			ptal_s3 <= 64'(ta_s2[31:0]) * 64'(mv_s2.elapsed);
			ptah_s3 <= 64'(ta_s2[63:32]) * 64'(mv_s2.elapsed);
			vv_s3   <= 64'(vu_s2) * 64'(vu_s2);
			va_s3   <= 64'(vu_s2) * 64'(acc);
			da_s3   <= 64'(mv_s2.distance) * 64'(acc);

			mv_s4 <= mv_s3;
			br_s4 <= br_s3;
			p1_s4 <= {32'd0, ptvl_s3} + {ptvh_s3, 32'd0};
			p2_s4 <= {32'd0, ptal_s3} + {ptah_s3, 32'd0};
			vv_s4 <= vv_s3;
			va_s4 <= va_s3;
			da_s4 <= da_s3;

			mv_s5   <= mv_s4;
			br_s5   <= br_s4;
			sacc_s5 <= sacc_c[95:33];
			num_s5  <= {p1_s4, 1'b0} - {17'd0, vv_s4, 16'd0};
			xm_s5   <= 82'(xw_c - p1w_c);
			done_s5 <= (p1w_c >= xw_c);
			va_s5   <= va_s4;

			mv_s6   <= mv_s5;
			br_s6   <= br_s5;
			sacc_s6 <= sacc_s5;
			done_s6 <= done_s5;
			if (br_s5 == tpp_pkg::BR_CRUISE) begin
				nd_s6  <= {1'b0, cr_c[97:17]};
				den_s6 <= {32'd0, acc};
			end else begin
				nd_s6  <= xm_s5 + {19'd0, va_s5[63:1]};
				den_s6 <= va_s5;
			end

			dv_q[0] <= '{mv: mv_s6, br: br_s6, done: done_s6, sacc: sacc_s6};
			for (int i = 1; i < DVN; i++) begin
				dv_q[i] <= dv_q[i-1];
			end

			sd_s7  <= dv_q[DVN-1];
			q_s7   <= quot;
			aql_s7 <= 64'(acc) * 64'(quot[31:0]);
			aqh_s7 <= 50'(acc) * 50'(quot[49:32]);

			sd_s8 <= sd_s7;
			q_s8  <= q_s7;
			m_s8  <= aql_s7 + {aqh_s7[31:0], 32'd0};

			sd_s9  <= sd_s8;
			q_s9   <= q_s8;
			pll_s9 <= 64'(m_s8[31:0]) * 64'(q_s8[31:0]);
			plh_s9 <= 50'(m_s8[31:0]) * 50'(q_s8[49:32]);
			phl_s9 <= 64'(m_s8[63:32]) * 64'(q_s8[31:0]);
			phh_s9 <= 50'(m_s8[63:32]) * 50'(q_s8[49:32]);

			sd_s10   <= sd_s9;
			q_s10    <= q_s9;
			prod_s10 <= {50'd0, pll_s9} + {32'd0, plh_s9, 32'd0}
				+ {18'd0, phl_s9, 32'd0} + {phh_s9, 64'd0};

			sd_s11 <= sd_s10;
			q_s11  <= q_s10;
			d_s11  <= d_c;

			sd_s12 <= sd_s11;
			s_s12  <= (sx_c > dist64_c) ? sd_s11.mv.distance : sx_c[31:0];

			mv_s13 <= sd_s12.mv;
			priority if (sd_s12.mv.zero) begin
				pos_s13 <= sd_s12.mv.target;
			end else if (sd_s12.mv.neg) begin
				pos_s13 <= sd_s12.mv.start - s_s12;
			end else begin
				pos_s13 <= sd_s12.mv.start + s_s12;
			end
		end
	end

	assign out_valid = v_s13;
	assign out_pos   = pos_s13;

	a_out_between: assert property (@(posedge clk) disable iff (!arst_n)
		v_s13 && !mv_s13.zero |->
			(mv_s13.neg ?
				($signed(pos_s13) <= $signed(mv_s13.start) &&
				 $signed(pos_s13) >= $signed(mv_s13.target)) :
				($signed(pos_s13) >= $signed(mv_s13.start) &&
				 $signed(pos_s13) <= $signed(mv_s13.target))))
		else $error("set position outside the move");

	a_cruise_quot: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 && !sd_s7.mv.zero && sd_s7.br == tpp_pkg::BR_CRUISE |->
			q_s7 <= DVN'(sd_s7.mv.distance))
		else $error("cruise travel exceeds distance");

	a_decel_quot: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 && !sd_s7.mv.zero && sd_s7.br == tpp_pkg::BR_DECEL && !sd_s7.done |->
			!q_s7[DVN-1])
		else $error("remaining time out of range");

endmodule

// ===== hw/rtl/trapezoidal_profile_position.sv =====
// Trapezoidal move set-point generator.
// Input words on s_axis carry a start position, a target position and the
// time since the move began; each gives one output word on m_axis with the
// position on a trapezoidal profile (accelerate, cruise, decelerate), or on a
// triangular one when the move is too short to reach max_velocity.
// Peak velocity and acceleration are written through the cfg channel
// (index 0 max_velocity, index 1 acceleration); the user must write them
// only while no word is in flight, which the block does not enforce.
// cfg_ready is always high. Throughput: one word per clock while m_axis
// does not stall. From input accept to output valid a word passes the queue,
// the 32-stage square root of distance times acceleration and the 50-stage
// divider that finds the cruise travel or the remaining deceleration time.
// A QUEUE_DEPTH word queue sits between input and evaluator. When m_axis
// stalls, the evaluator and its output word hold, and s_axis keeps taking
// words until the queue is full.
// Reset empties the queue and pipeline and sets both registers to 1.0.
module trapezoidal_profile_position #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // start_position, target_position, elapsed_time
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // set_position
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0]     vel_q, acc_q;
	logic [31:0]     vel, acc;
	logic            full, wr, pop;
	tpp_pkg::move_t  mv;
	tpp_pkg::qhead_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_q <= tpp_pkg::CFG_RESET;
			acc_q <= tpp_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tpp_pkg::REG_MAX_VELOCITY: vel_q <= cfg_data;
				tpp_pkg::REG_ACCELERATION: acc_q <= cfg_data;
			endcase
		end
	end

	// a zero register acts as one LSB
	assign vel = (vel_q == 32'd0) ? 32'd1 : vel_q;
	assign acc = (acc_q == 32'd0) ? 32'd1 : acc_q;

	tpp_front u_front (
		.in_valid (s_axis_tvalid),
		.in_data  (s_axis_tdata),
		.in_ready (s_axis_tready),
		.full     (full),
		.wr       (wr),
		.mv       (mv)
	);

	tpp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.wdata  (mv),
		.full   (full),
		.pop    (pop),
		.head   (head)
	);

	tpp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.vel       (vel),
		.acc       (acc),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pos   (m_axis_tdata)
	);

endmodule
